// ===== sv/abip_pkg.sv =====
// Shared types and constants of the auto-base integer parser.
// Used by abip_front, abip_back and the top level; depends on nothing.
package abip_pkg;

  // Character codes the classifier looks for.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Digit value of a byte that is no digit at all.
  localparam logic [5:0] DIGIT_NONE = 6'h3F;
  localparam logic [5:0] DIGIT_TEN  = 6'd10;

  // Number bases.
  localparam logic [4:0] BASE_OCT = 5'd8;
  localparam logic [4:0] BASE_DEC = 5'd10;
  localparam logic [4:0] BASE_HEX = 5'd16;

  // Queue sizes; both depths are powers of two so the pointers wrap freely.
  localparam int IQ_DEPTH = 4;
  localparam int IQ_PTR_W = $clog2(IQ_DEPTH);
  localparam int IQ_CNT_W = $clog2(IQ_DEPTH + 1);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  // A classified input byte.
  typedef struct packed {
    logic [5:0] digit;
    logic       is_space;
    logic       is_sign;
    logic       is_minus;
    logic       is_zero;
    logic       is_x;
  } cls_t;

  // Head of the queue between front and back.
  typedef struct packed {
    logic valid;
    cls_t cls;
  } cls_head_t;

  // One result item.
  typedef struct packed {
    logic [63:0] value;
    logic        wrapped;
    logic [4:0]  used_base;
    logic        last_of_run;
  } result_t;

  // Status of the result queue.
  typedef struct packed {
    logic                empty;
    logic [OQ_CNT_W-1:0] count;
  } oq_status_t;

endpackage

// ===== sv/ascii_integer_auto_base_parser.sv =====
// Top level of the auto-base ASCII integer parser.
// Instantiates abip_front and abip_back; depends on abip_pkg.
//
//   channel  handshake          payload
//   input    push / full        in_char_byte[7:0]
//   result   empty / pop        out_value[63:0] signed, out_wrapped,
//                               out_used_base[4:0], out_last_of_run
//
// A byte is written into the four-entry input queue at the edge that accepts
// it and, when the result queue has room, is taken by the back end, which
// writes any results that it causes into the result queue. A byte can cause
// two results and the back end takes a byte only while the four-entry result
// queue has room for two, so such bytes slow the input even when the consumer
// pops every cycle. Reset is synchronous and clears all but the queue storage.
module ascii_integer_auto_base_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic [7:0]         in_char_byte,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output logic signed [63:0] out_value,
  output logic               out_wrapped,
  output logic [4:0]         out_used_base,
  output logic               out_last_of_run
);
  import abip_pkg::*;

  cls_head_t  head;
  logic       take;
  result_t    res_head;
  oq_status_t status;

  // The front classifies bytes (digit value, white space, sign, prefix x)
  // so that the back end sees only a few flags and a digit value.
  abip_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .in_char_byte (in_char_byte),
    .full         (full),
    .head         (head),
    .take         (take)
  );

  // The back end runs the number state machine and holds finished results.
  abip_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .take     (take),
    .res_head (res_head),
    .status   (status),
    .pop      (pop)
  );

  assign empty           = status.empty;
  assign out_value       = signed'(res_head.value);
  assign out_wrapped     = res_head.wrapped;
  assign out_used_base   = res_head.used_base;
  assign out_last_of_run = res_head.last_of_run;

  // The back end never takes a byte that the input queue does not hold.
  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> head.valid)
    else $error("back end took a byte from an empty input queue");

  // The result queue never holds more than its depth.
  a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    status.count <= OQ_CNT_W'(OQ_DEPTH))
    else $error("result queue overflow");

  // Results leave only by a pop.
  a_oq_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !empty) |=> status.count >= $past(status.count))
    else $error("result lost without a pop");

  // After reset no result is offered.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("result queue not empty after reset");

endmodule

// ===== sv/abip_front.sv =====
// Front end of the parser: classifies each byte and queues it for the back end.
// Depends on abip_pkg.
module abip_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [7:0]        in_char_byte,
  output logic              full,
  output abip_pkg::cls_head_t head,
  input  logic              take
);
  import abip_pkg::*;

  cls_t                cls;
  cls_t                mem [IQ_DEPTH];
  logic [IQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [IQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [IQ_CNT_W-1:0] count_r, count_nxt;
  logic                push_acc;
  logic                pop_acc;

  always_comb begin
    cls = '0;
    if (in_char_byte inside {[CH_ZERO:CH_NINE]}) begin
      cls.digit = 6'(in_char_byte - CH_ZERO);
    end else if (in_char_byte inside {[CH_UP_A:CH_UP_Z]}) begin
      cls.digit = 6'(in_char_byte - CH_UP_A) + DIGIT_TEN;
    end else if (in_char_byte inside {[CH_LO_A:CH_LO_Z]}) begin
      cls.digit = 6'(in_char_byte - CH_LO_A) + DIGIT_TEN;
    end else begin
      cls.digit = DIGIT_NONE;
    end
    cls.is_space = (in_char_byte == CH_SPACE) || (in_char_byte inside {[CH_TAB:CH_CR]});
    cls.is_sign  = (in_char_byte == CH_MINUS) || (in_char_byte == CH_PLUS);
    cls.is_minus = (in_char_byte == CH_MINUS);
    cls.is_zero  = (in_char_byte == CH_ZERO);
    cls.is_x     = (in_char_byte == CH_LO_X) || (in_char_byte == CH_UP_X);
  end

  assign full     = (count_r == IQ_CNT_W'(IQ_DEPTH));
  assign push_acc = push && !full;
  assign pop_acc  = take && (count_r != '0);

  assign head.valid = (count_r != '0);
  assign head.cls   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + IQ_PTR_W'(push_acc);
    rd_ptr_nxt = rd_ptr_r + IQ_PTR_W'(pop_acc);
    count_nxt  = count_r + IQ_CNT_W'(push_acc) - IQ_CNT_W'(pop_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_acc) begin
      mem[wr_ptr_r] <= cls;
    end
  end

endmodule

// ===== sv/abip_back.sv =====
// Back end of the parser: number state machine, accumulator and result queue.
// Depends on abip_pkg; fed by abip_front.
module abip_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  abip_pkg::cls_head_t  head,
  output logic                 take,
  output abip_pkg::result_t    res_head,
  output abip_pkg::oq_status_t status,
  input  logic                 pop
);
  import abip_pkg::*;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_SIGNED = 3'd1;
  localparam logic [2:0] PH_ZEROS  = 3'd2;
  localparam logic [2:0] PH_DIGITS = 3'd3;

  logic [2:0]  phase_r, phase_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic        neg_r, neg_nxt;
  logic [4:0]  base_r, base_nxt;

  result_t             mem [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OQ_CNT_W-1:0] count_r, count_nxt;
  logic                pop_acc;

  cls_t        c;
  logic [63:0] scaled;
  logic [63:0] sum;
  logic        wrap;
  logic        fin;
  logic [63:0] fin_val;
  logic        fin_wr;
  logic        rej;
  logic        do_idle;
  logic        do_start;
  result_t     r_fin;
  result_t     r_rej;
  logic [1:0]  nres;

  assign c = head.cls;

  // Multiply by the base as shifts; decimal is 8x + 2x.
  always_comb begin
    case (base_r)
      BASE_OCT: scaled = {acc_r[60:0], 3'b000};
      BASE_HEX: scaled = {acc_r[59:0], 4'b0000};
      default:  scaled = {acc_r[60:0], 3'b000} + {acc_r[62:0], 1'b0};
    endcase
    sum  = scaled + {58'd0, c.digit};
    wrap = (sum < acc_r);
  end

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    base_nxt  = base_r;
    fin       = 1'b0;
    fin_val   = '0;
    fin_wr    = 1'b0;
    rej       = 1'b0;
    do_idle   = 1'b0;
    do_start  = 1'b0;

    case (phase_r)
      PH_SIGNED: begin
        do_start = 1'b1;
      end
      PH_ZEROS: begin
        if (c.is_zero) begin
          phase_nxt = PH_ZEROS;
        end else if (c.is_x) begin
          base_nxt  = BASE_HEX;
          acc_nxt   = '0;
          phase_nxt = PH_DIGITS;
        end else if (c.digit < 6'd8) begin
          acc_nxt   = {58'd0, c.digit};
          phase_nxt = PH_DIGITS;
        end else begin
          fin     = 1'b1;
          do_idle = 1'b1;
        end
      end
      PH_DIGITS: begin
        if (c.digit < {1'b0, base_r}) begin
          if (wrap) begin
            fin     = 1'b1;
            fin_val = acc_r;
            fin_wr  = 1'b1;
            do_idle = 1'b1;
          end else begin
            acc_nxt = sum;
          end
        end else begin
          fin     = 1'b1;
          fin_val = acc_r;
          do_idle = 1'b1;
        end
      end
      default: begin
        do_idle = 1'b1;
      end
    endcase

    // The ending byte of a number is looked at again as if idle.
    if (do_idle) begin
      phase_nxt = PH_IDLE;
      acc_nxt   = '0;
      neg_nxt   = 1'b0;
      base_nxt  = BASE_DEC;
      if (c.is_space) begin
        phase_nxt = PH_IDLE;
      end else if (c.is_sign) begin
        neg_nxt   = c.is_minus;
        phase_nxt = PH_SIGNED;
      end else begin
        do_start = 1'b1;
      end
    end

    if (do_start) begin
      if (c.is_zero) begin
        base_nxt  = BASE_OCT;
        phase_nxt = PH_ZEROS;
      end else if (c.digit < DIGIT_TEN) begin
        base_nxt  = BASE_DEC;
        acc_nxt   = {58'd0, c.digit};
        phase_nxt = PH_DIGITS;
      end else begin
        rej       = 1'b1;
        phase_nxt = PH_IDLE;
        acc_nxt   = '0;
        neg_nxt   = 1'b0;
        base_nxt  = BASE_DEC;
      end
    end

    r_fin.value       = neg_r ? (64'd0 - fin_val) : fin_val;
    r_fin.wrapped     = fin_wr;
    r_fin.used_base   = base_r;
    r_fin.last_of_run = !rej;
    r_rej.value       = '0;
    r_rej.wrapped     = 1'b0;
    r_rej.used_base   = BASE_DEC;
    r_rej.last_of_run = 1'b1;
  end

  // A byte is taken only when the result queue has room for two results.
  assign take    = head.valid && (count_r <= OQ_CNT_W'(OQ_DEPTH - 2));
  assign pop_acc = pop && (count_r != '0);
  assign nres    = take ? (2'(fin) + 2'(rej)) : 2'd0;

  assign res_head     = mem[rd_ptr_r];
  assign status.empty = (count_r == '0);
  assign status.count = count_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + OQ_PTR_W'(nres);
    rd_ptr_nxt = rd_ptr_r + OQ_PTR_W'(pop_acc);
    count_nxt  = count_r + OQ_CNT_W'(nres) - OQ_CNT_W'(pop_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      acc_r    <= '0;
      neg_r    <= 1'b0;
      base_r   <= BASE_DEC;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (take) begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        neg_r   <= neg_nxt;
        base_r  <= base_nxt;
      end
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (fin) begin
        mem[wr_ptr_r] <= r_fin;
        if (rej) begin
          mem[wr_ptr_r + OQ_PTR_W'(1)] <= r_rej;
        end
      end else if (rej) begin
        mem[wr_ptr_r] <= r_rej;
      end
    end
  end

endmodule
